### sv/irx_pkg.sv
`timescale 1ns / 1ps
package irx_pkg;
	localparam int NumRegsDefault  = 64;
	localparam int NumSlotsDefault = 64;

	typedef enum logic [4:0] {
		OP_LDC = 5'd0, OP_LDS = 5'd1, OP_CPY = 5'd2, OP_ADD = 5'd3, OP_SUB = 5'd4,
		OP_MUL = 5'd5, OP_DIV = 5'd6, OP_REM = 5'd7, OP_EQ = 5'd8, OP_NE = 5'd9,
		OP_LT = 5'd10, OP_LE = 5'd11, OP_GT = 5'd12, OP_GE = 5'd13, OP_LAND = 5'd14,
		OP_LOR = 5'd15, OP_XOR = 5'd16, OP_SHL = 5'd17, OP_SHR = 5'd18, OP_NEG = 5'd19,
		OP_LNOT = 5'd20, OP_BNOT = 5'd21, OP_SLD = 5'd22, OP_SST = 5'd23, OP_RET = 5'd24,
		OP_BR = 5'd25, OP_JMP = 5'd26, OP_TRAP = 5'd27
	} op_t;

	localparam logic [1:0] ST_CONTINUE = 2'd0;
	localparam logic [1:0] ST_RETURNED = 2'd1;
	localparam logic [1:0] ST_TRAPPED  = 2'd2;

	localparam logic [2:0] REG_REG_COUNT   = 3'd0;
	localparam logic [2:0] REG_SLOT_COUNT  = 3'd1;
	localparam logic [2:0] REG_CONST_COUNT = 3'd2;
	localparam logic [2:0] REG_STR_COUNT   = 3'd3;
	localparam logic [2:0] REG_BODY_LEN    = 3'd4;
	localparam logic [2:0] REG_RET_REG     = 3'd5;
	localparam logic [2:0] REG_RET_EXIT    = 3'd6;

	typedef struct packed {
		logic [4:0]  opcode;
		logic [7:0]  dest_index;
		logic [7:0]  left_index;
		logic [7:0]  right_index;
		logic [15:0] immediate;
		logic [63:0] const_word;
	} instr_t;

	typedef struct packed {
		logic [1:0]  run_status;
		logic [15:0] next_pc;
		logic [63:0] exit_value;
	} result_t;

	typedef struct packed {
		logic [6:0]  reg_count;
		logic [6:0]  slot_count;
		logic [15:0] const_count;
		logic [15:0] string_count;
		logic [15:0] body_length;
		logic [7:0]  return_register;
		logic        return_is_exit_code;
	} cfg_t;
endpackage

### sv/irx_stream_if.sv
`timescale 1ns / 1ps
interface irx_stream_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### sv/irx_front.sv
`timescale 1ns / 1ps
module irx_front (
	input  logic clk,
	input  logic arst_n,
	irx_stream_if.sink in_ch,
	output logic            q_valid,
	input  logic            q_pop,
	output irx_pkg::instr_t q_data
);
	import irx_pkg::*;
	instr_t     mem_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       push;

	assign in_ch.ready = (cnt_q != 2'd2);
	assign push = in_ch.valid && in_ch.ready;
	assign q_valid = (cnt_q != 2'd0);
	assign q_data = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_ch.payload;
	end
endmodule

### sv/irx_divider.sv
`timescale 1ns / 1ps
module irx_divider (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] quot,
	output logic [63:0] rem
);
	logic [63:0] q_q, r_q, d_q;
	logic [6:0]  cnt_q;
	logic        busy_q, nq_q, nr_q;
	logic [64:0] trial;
	logic [63:0] rs;

	assign rs = {r_q[62:0], q_q[63]};
	assign trial = {1'b0, rs} - {1'b0, d_q};
	assign quot = nq_q ? -q_q : q_q;
	assign rem = nr_q ? -r_q : r_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= 7'd64;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 7'd1;
				if (cnt_q == 7'd1) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q <= a[63] ? -a : a;
			d_q <= b[63] ? -b : b;
			r_q <= '0;
			nq_q <= a[63] ^ b[63];
			nr_q <= a[63];
		end else if (busy_q) begin
			if (!trial[64]) begin
				r_q <= trial[63:0];
				q_q <= {q_q[62:0], 1'b1};
			end else begin
				r_q <= rs;
				q_q <= {q_q[62:0], 1'b0};
			end
		end
	end
endmodule

### sv/irx_back.sv
`timescale 1ns / 1ps
module irx_back #(
	parameter int NUM_REGS  = irx_pkg::NumRegsDefault,
	parameter int NUM_SLOTS = irx_pkg::NumSlotsDefault
) (
	input  logic            clk,
	input  logic            arst_n,
	input  irx_pkg::cfg_t   cfg,
	input  logic            q_valid,
	output logic            q_pop,
	input  irx_pkg::instr_t q_data,
	irx_stream_if.source out_ch
);
	import irx_pkg::*;
	localparam int RW = $clog2(NUM_REGS);
	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	typedef enum logic [2:0] {S_IDLE, S_READ, S_EXEC, S_MUL, S_DIV, S_OUT} state_t;
	state_t state_q;

	logic [63:0] rf_q [NUM_REGS];
	logic [63:0] sl_q [NUM_SLOTS];
	logic [NUM_REGS-1:0]  rf_vld_q;
	logic [NUM_SLOTS-1:0] sl_vld_q;
	logic [15:0] pc_q;
	logic [1:0]  halt_q;
	instr_t      ins_q;
	logic [63:0] a_q, b_q, s_q, prod_q;
	logic [1:0]  mstep_q;
	logic [31:0] mx, my;
	logic [63:0] mp;
	result_t     res_q;
	logic        div_start, div_done;
	logic [63:0] div_quot, div_rem;
	logic        commit;

	logic [8:0] rb, sb;
	logic       dbad, lbad, rbad, ibad_s, rrok;
	logic [1:0] st;
	logic [15:0] npc;
	logic       wr_en, sst_en;
	logic [63:0] v;
	logic [RW-1:0] l_ix, r_ix, d_ix, rr_ix, b_ix;
	logic [SW-1:0] s_ix;

	assign rb = (cfg.reg_count < 7'(NUM_REGS > 127 ? 127 : NUM_REGS) || NUM_REGS > 127)
		? {2'b0, cfg.reg_count} : 9'(NUM_REGS);
	assign sb = ({2'b0, cfg.slot_count} < 9'(NUM_SLOTS)) ? {2'b0, cfg.slot_count}
		: 9'(NUM_SLOTS);
	assign dbad = {1'b0, ins_q.dest_index} >= rb;
	assign lbad = {1'b0, ins_q.left_index} >= rb;
	assign rbad = {1'b0, ins_q.right_index} >= rb;
	assign ibad_s = {1'b0, ins_q.immediate} >= {8'b0, sb};
	assign rrok = {1'b0, cfg.return_register} < rb;
	assign l_ix = ins_q.left_index[RW-1:0];
	assign r_ix = ins_q.right_index[RW-1:0];
	assign d_ix = ins_q.dest_index[RW-1:0];
	assign rr_ix = cfg.return_register[RW-1:0];
	assign b_ix = (ins_q.opcode == OP_RET) ? rr_ix : r_ix;
	assign s_ix = ins_q.immediate[SW-1:0];

	assign mx = (mstep_q == 2'd2) ? a_q[63:32] : a_q[31:0];
	assign my = (mstep_q == 2'd1) ? b_q[63:32] : b_q[31:0];
	assign mp = {32'd0, mx} * {32'd0, my};

	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign out_ch.valid = (state_q == S_OUT);
	assign out_ch.payload = res_q;
	assign div_start = (state_q == S_EXEC) && (ins_q.opcode == OP_DIV || ins_q.opcode == OP_REM)
		&& halt_q == ST_CONTINUE && pc_q < cfg.body_length && !dbad && !lbad && !rbad
		&& b_q != 64'd0;
	assign commit = (state_q == S_EXEC && !div_start) || (state_q == S_DIV && div_done);

	irx_divider u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .a(a_q), .b(b_q),
		.done(div_done), .quot(div_quot), .rem(div_rem)
	);

	always_comb begin
		st = ST_CONTINUE;
		npc = pc_q + 16'd1;
		wr_en = 1'b0;
		sst_en = 1'b0;
		v = '0;
		if (halt_q != ST_CONTINUE) begin
			st = halt_q;
		end else if (pc_q >= cfg.body_length) begin
			st = ST_TRAPPED;
		end else begin
			case (ins_q.opcode)
				OP_LDC: begin
					if (dbad || ins_q.immediate >= cfg.const_count) st = ST_TRAPPED;
					else begin wr_en = 1'b1; v = ins_q.const_word; end
				end
				OP_LDS: begin
					if (dbad || ins_q.immediate >= cfg.string_count) st = ST_TRAPPED;
					else begin wr_en = 1'b1; v = {48'd0, ins_q.immediate}; end
				end
				OP_CPY, OP_NEG, OP_LNOT, OP_BNOT: begin
					if (dbad || lbad) st = ST_TRAPPED;
					else begin
						wr_en = 1'b1;
						case (ins_q.opcode)
							OP_CPY:  v = a_q;
							OP_NEG:  v = -a_q;
							OP_LNOT: v = {63'd0, a_q == 64'd0};
							default: v = ~a_q;
						endcase
					end
				end
				OP_SLD: begin
					if (dbad || ibad_s) st = ST_TRAPPED;
					else begin wr_en = 1'b1; v = s_q; end
				end
				OP_SST: begin
					if (ibad_s || lbad) st = ST_TRAPPED;
					else sst_en = 1'b1;
				end
				OP_RET: st = ST_RETURNED;
				OP_BR: begin
					if (lbad) st = ST_TRAPPED;
					else if (a_q != 64'd0) npc = ins_q.immediate;
				end
				OP_JMP: begin
					if (ins_q.immediate >= cfg.body_length) st = ST_TRAPPED;
					else npc = ins_q.immediate;
				end
				OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_REM, OP_EQ, OP_NE, OP_LT, OP_LE,
				OP_GT, OP_GE, OP_LAND, OP_LOR, OP_XOR, OP_SHL, OP_SHR: begin
					if (dbad || lbad || rbad) st = ST_TRAPPED;
					else begin
						wr_en = 1'b1;
						case (ins_q.opcode)
							OP_ADD: v = a_q + b_q;
							OP_SUB: v = a_q - b_q;
							OP_MUL: v = prod_q;
							OP_DIV, OP_REM: begin
								if (b_q == 64'd0) begin st = ST_TRAPPED; wr_en = 1'b0; end
								else v = (ins_q.opcode == OP_DIV) ? div_quot : div_rem;
							end
							OP_EQ: v = {63'd0, a_q == b_q};
							OP_NE: v = {63'd0, a_q != b_q};
							OP_LT: v = {63'd0, $signed(a_q) < $signed(b_q)};
							OP_LE: v = {63'd0, $signed(a_q) <= $signed(b_q)};
							OP_GT: v = {63'd0, $signed(a_q) > $signed(b_q)};
							OP_GE: v = {63'd0, $signed(a_q) >= $signed(b_q)};
							OP_LAND: v = {63'd0, a_q != 64'd0 && b_q != 64'd0};
							OP_LOR: v = {63'd0, a_q != 64'd0 || b_q != 64'd0};
							OP_XOR: v = a_q ^ b_q;
							default: begin
								if (b_q[63]) begin st = ST_TRAPPED; wr_en = 1'b0; end
								else if (ins_q.opcode == OP_SHL)
									v = (b_q[62:6] != '0) ? 64'd0 : a_q << b_q[5:0];
								else
									v = (b_q[62:6] != '0) ? {64{a_q[63]}}
										: 64'($signed(a_q) >>> b_q[5:0]);
							end
						endcase
					end
				end
				default: st = ST_TRAPPED;
			endcase
		end
		if (st != ST_CONTINUE) begin
			npc = pc_q;
			wr_en = 1'b0;
			sst_en = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pc_q <= '0;
			halt_q <= ST_CONTINUE;
			mstep_q <= '0;
			rf_vld_q <= '0;
			sl_vld_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_valid) state_q <= S_READ;
				S_READ: begin
					mstep_q <= '0;
					state_q <= (ins_q.opcode == OP_MUL) ? S_MUL : S_EXEC;
				end
				S_MUL: begin
					mstep_q <= mstep_q + 2'd1;
					if (mstep_q == 2'd2) state_q <= S_EXEC;
				end
				S_EXEC, S_DIV: begin
					if (div_start) state_q <= S_DIV;
					else if (commit) begin
						state_q <= S_OUT;
						pc_q <= npc;
						halt_q <= st;
						if (wr_en) rf_vld_q[d_ix] <= 1'b1;
						if (sst_en) sl_vld_q[s_ix] <= 1'b1;
					end
				end
				S_OUT: if (out_ch.ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) ins_q <= q_data;
		if (state_q == S_READ) begin
			a_q <= rf_vld_q[l_ix] ? rf_q[l_ix] : 64'd0;
			b_q <= rf_vld_q[b_ix] ? rf_q[b_ix] : 64'd0;
			s_q <= sl_vld_q[s_ix] ? sl_q[s_ix] : 64'd0;
		end
		if (state_q == S_MUL) begin
			if (mstep_q == 2'd0) prod_q <= mp;
			else prod_q[63:32] <= prod_q[63:32] + mp[31:0];
		end
		if (commit && wr_en) rf_q[d_ix] <= v;
		if (commit && sst_en) sl_q[s_ix] <= a_q;
		if (commit) begin
			res_q.run_status <= st;
			res_q.next_pc <= npc;
			res_q.exit_value <= (halt_q == ST_CONTINUE && st == ST_RETURNED
				&& pc_q < cfg.body_length && cfg.return_is_exit_code && rrok)
				? b_q : 64'd0;
		end
	end
endmodule

### sv/ir_register_machine_execute.sv
`timescale 1ns / 1ps
// Register machine execute stage.
// in: one beat per instruction (opcode, indices, immediate, constant word).
// out: one beat per instruction (run_status, next_pc, exit_value).
// Configuration through the APB port; reads return the value. The user must
// write it only while idle; the block itself does not enforce this.
// A two-entry queue parts the accepting front from the executing back, so the
// input takes beats while a result waits on a stalled receiver.
// Multiply forms three 32x32 partial products; divide and remainder use a
// 64-step shift-subtract divider. The back executes one instruction at a time
// through register read, execute and result stages, and takes no new
// instruction until the receiver has taken the previous result.
// Reset clears register file, slot store, program counter, halt state and the
// configuration to its defaults. When out.ready is low the result holds and
// the back waits; the front keeps filling the queue until it is full.
// Once returned or trapped, every later beat repeats that status.
module ir_register_machine_execute #(
	parameter int NUM_REGS  = irx_pkg::NumRegsDefault,
	parameter int NUM_SLOTS = irx_pkg::NumSlotsDefault
) (
	input  logic        clk,
	input  logic        arst_n,
	irx_stream_if.sink   in_ch,
	irx_stream_if.source out_ch,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import irx_pkg::*;
	cfg_t   cfg_q;
	logic   qv, qp;
	instr_t qd;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{reg_count: 7'd64, slot_count: 7'd0, const_count: 16'd0,
				string_count: 16'd0, body_length: 16'd0, return_register: 8'd0,
				return_is_exit_code: 1'b0};
		end else if (psel && penable && pwrite) begin
			case (paddr[4:2])
				REG_REG_COUNT:   cfg_q.reg_count <= pwdata[6:0];
				REG_SLOT_COUNT:  cfg_q.slot_count <= pwdata[6:0];
				REG_CONST_COUNT: cfg_q.const_count <= pwdata[15:0];
				REG_STR_COUNT:   cfg_q.string_count <= pwdata[15:0];
				REG_BODY_LEN:    cfg_q.body_length <= pwdata[15:0];
				REG_RET_REG:     cfg_q.return_register <= pwdata[7:0];
				REG_RET_EXIT:    cfg_q.return_is_exit_code <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[4:2])
			REG_REG_COUNT:   prdata = {25'd0, cfg_q.reg_count};
			REG_SLOT_COUNT:  prdata = {25'd0, cfg_q.slot_count};
			REG_CONST_COUNT: prdata = {16'd0, cfg_q.const_count};
			REG_STR_COUNT:   prdata = {16'd0, cfg_q.string_count};
			REG_BODY_LEN:    prdata = {16'd0, cfg_q.body_length};
			REG_RET_REG:     prdata = {24'd0, cfg_q.return_register};
			REG_RET_EXIT:    prdata = {31'd0, cfg_q.return_is_exit_code};
			default:         prdata = '0;
		endcase
	end

	irx_front u_front (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .q_valid(qv), .q_pop(qp), .q_data(qd)
	);

	irx_back #(.NUM_REGS(NUM_REGS), .NUM_SLOTS(NUM_SLOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg_q), .q_valid(qv), .q_pop(qp), .q_data(qd),
		.out_ch(out_ch)
	);
endmodule

### sv/irx_checker.sv
`timescale 1ns / 1ps
module irx_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_ready,
	input logic [81:0] out_payload
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_payload))
		else $error("result beat dropped or changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_payload[81:80] != 2'd3)
		else $error("bad run status");
	a_known: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !$isunknown(out_payload))
		else $error("unknown bits in result beat");
	a_exit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_payload[81:80] != 2'd1 |-> out_payload[63:0] == 64'd0)
		else $error("exit value set outside a return");
endmodule

bind ir_register_machine_execute irx_checker u_chk (
	.clk(clk), .arst_n(arst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.out_payload(out_ch.payload)
);

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
	import irx_pkg::*;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	irx_stream_if #(.W($bits(instr_t)))  in_if ();
	irx_stream_if #(.W($bits(result_t))) out_if ();

	ir_register_machine_execute dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_if), .out_ch(out_if),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// machine state as predicted
	logic [63:0] regs [64];
	logic [63:0] slots [64];
	logic [15:0] pc;
	logic [1:0]  halt;
	cfg_t        cfg;

	result_t     pending_results [$];
	int          n_instr;
	int          n_results;
	int          n_errors;
	int          idle_cycles;
	int          stall_left;
	int          halt_case;
	bit          quiet;

	function automatic int unsigned reg_bound();
		return cfg.reg_count < 64 ? cfg.reg_count : 64;
	endfunction

	function automatic int unsigned slot_bound();
		return cfg.slot_count < 64 ? cfg.slot_count : 64;
	endfunction

	function automatic result_t execute_instr(instr_t x);
		result_t     res;
		logic [63:0] a, b, v, ma, mb, q;
		logic [1:0]  st;
		logic [15:0] npc;
		logic [63:0] ev;
		int unsigned rb, sb;
		rb = reg_bound();
		sb = slot_bound();
		st = ST_CONTINUE;
		npc = pc + 16'd1;
		ev = '0;
		v = '0;
		if (halt != ST_CONTINUE) begin
			st = halt;
		end else if (pc >= cfg.body_length) begin
			st = ST_TRAPPED;
		end else if (x.opcode == OP_LDC) begin
			if (x.dest_index >= rb || x.immediate >= cfg.const_count) st = ST_TRAPPED;
			else regs[x.dest_index] = x.const_word;
		end else if (x.opcode == OP_LDS) begin
			if (x.dest_index >= rb || x.immediate >= cfg.string_count) st = ST_TRAPPED;
			else regs[x.dest_index] = {48'd0, x.immediate};
		end else if (x.opcode == OP_CPY) begin
			if (x.dest_index >= rb || x.left_index >= rb) st = ST_TRAPPED;
			else regs[x.dest_index] = regs[x.left_index];
		end else if (x.opcode >= OP_ADD && x.opcode <= OP_SHR) begin
			if (x.dest_index >= rb || x.left_index >= rb || x.right_index >= rb) begin
				st = ST_TRAPPED;
			end else begin
				a = regs[x.left_index];
				b = regs[x.right_index];
				ma = a[63] ? -a : a;
				mb = b[63] ? -b : b;
				case (x.opcode)
					OP_ADD: v = a + b;
					OP_SUB: v = a - b;
					OP_MUL: v = a * b;
					OP_DIV: begin
						if (b == 0) st = ST_TRAPPED;
						else begin
							q = ma / mb;
							v = (a[63] ^ b[63]) ? -q : q;
						end
					end
					OP_REM: begin
						if (b == 0) st = ST_TRAPPED;
						else begin
							q = ma % mb;
							v = a[63] ? -q : q;
						end
					end
					OP_EQ:   v = {63'd0, a == b};
					OP_NE:   v = {63'd0, a != b};
					OP_LT:   v = {63'd0, $signed(a) < $signed(b)};
					OP_LE:   v = {63'd0, $signed(a) <= $signed(b)};
					OP_GT:   v = {63'd0, $signed(a) > $signed(b)};
					OP_GE:   v = {63'd0, $signed(a) >= $signed(b)};
					OP_LAND: v = {63'd0, a != 0 && b != 0};
					OP_LOR:  v = {63'd0, a != 0 || b != 0};
					OP_XOR:  v = a ^ b;
					OP_SHL: begin
						if (b[63]) st = ST_TRAPPED;
						else v = b >= 64 ? 64'd0 : a << b[5:0];
					end
					default: begin
						if (b[63]) st = ST_TRAPPED;
						else v = b >= 64 ? {64{a[63]}} : $unsigned($signed(a) >>> b[5:0]);
					end
				endcase
				if (st == ST_CONTINUE) regs[x.dest_index] = v;
			end
		end else if (x.opcode >= OP_NEG && x.opcode <= OP_BNOT) begin
			if (x.dest_index >= rb || x.left_index >= rb) begin
				st = ST_TRAPPED;
			end else begin
				a = regs[x.left_index];
				if (x.opcode == OP_NEG) regs[x.dest_index] = -a;
				else if (x.opcode == OP_LNOT) regs[x.dest_index] = {63'd0, a == 0};
				else regs[x.dest_index] = ~a;
			end
		end else if (x.opcode == OP_SLD) begin
			if (x.dest_index >= rb || x.immediate >= sb) st = ST_TRAPPED;
			else regs[x.dest_index] = slots[x.immediate[5:0]];
		end else if (x.opcode == OP_SST) begin
			if (x.immediate >= sb || x.left_index >= rb) st = ST_TRAPPED;
			else slots[x.immediate[5:0]] = regs[x.left_index];
		end else if (x.opcode == OP_RET) begin
			st = ST_RETURNED;
			if (cfg.return_is_exit_code && cfg.return_register < rb)
				ev = regs[cfg.return_register[5:0]];
		end else if (x.opcode == OP_BR) begin
			if (x.left_index >= rb) st = ST_TRAPPED;
			else if (regs[x.left_index] != 0) npc = x.immediate;
		end else if (x.opcode == OP_JMP) begin
			if (x.immediate >= cfg.body_length) st = ST_TRAPPED;
			else npc = x.immediate;
		end else begin
			st = ST_TRAPPED;
		end
		if (st != ST_CONTINUE) begin
			npc = pc;
			halt = st;
		end
		pc = npc;
		res.run_status = st;
		res.next_pc = pc;
		res.exit_value = ev;
		return res;
	endfunction

	function automatic instr_t mk(logic [4:0] op, logic [7:0] d, logic [7:0] l,
			logic [7:0] r, logic [15:0] imm, logic [63:0] cw);
		instr_t x;
		x.opcode = op;
		x.dest_index = d;
		x.left_index = l;
		x.right_index = r;
		x.immediate = imm;
		x.const_word = cw;
		return x;
	endfunction

	// well-formed instruction at the current pc, random content
	function automatic instr_t gen_instr();
		instr_t      x;
		int unsigned rb, sb;
		logic [4:0]  op;
		bit          ok;
		rb = reg_bound();
		sb = slot_bound();
		x = mk($urandom, $urandom, $urandom, $urandom, $urandom, {$urandom, $urandom});
		case ($urandom_range(0, 7))
			0: x.const_word = 64'h8000_0000_0000_0000;
			1: x.const_word = 64'h7fff_ffff_ffff_ffff;
			2: x.const_word = '1;
			3: x.const_word = $urandom_range(0, 70);
			default: ;
		endcase
		if (32'(pc) + 1 >= cfg.body_length) begin
			x.opcode = OP_JMP;
			x.immediate = $urandom_range(0, cfg.body_length - 1);
			return x;
		end
		ok = 0;
		while (!ok) begin
			op = $urandom_range(OP_LDC, OP_JMP);
			ok = !(op == OP_RET || (op == OP_LDC && cfg.const_count == 0)
				|| (op == OP_LDS && cfg.string_count == 0)
				|| ((op == OP_SLD || op == OP_SST) && sb == 0));
		end
		x.dest_index = $urandom_range(0, rb - 1);
		x.left_index = $urandom_range(0, rb - 1);
		x.right_index = $urandom_range(0, rb - 1);
		if ((op == OP_DIV || op == OP_REM) && regs[x.right_index] == 0) op = OP_ADD;
		if ((op == OP_SHL || op == OP_SHR) && regs[x.right_index][63]) op = OP_SUB;
		x.opcode = op;
		case (op)
			OP_LDC: x.immediate = $urandom_range(0, cfg.const_count - 1);
			OP_LDS: x.immediate = $urandom_range(0, cfg.string_count - 1);
			OP_SLD, OP_SST: x.immediate = $urandom_range(0, sb - 1);
			OP_BR, OP_JMP: x.immediate = $urandom_range(0, cfg.body_length - 1);
			default: ;
		endcase
		return x;
	endfunction

	task automatic send_instr(input instr_t x);
		int      gap;
		result_t r;
		gap = quiet ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			in_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_if.valid <= 1'b1;
		in_if.payload <= x;
		do @(posedge clk); while (!in_if.ready);
		r = execute_instr(x);
		pending_results.insert(pending_results.size(), r);
		n_instr++;
	endtask

	task automatic cfg_write(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_REG_COUNT:   cfg.reg_count = val[6:0];
			REG_SLOT_COUNT:  cfg.slot_count = val[6:0];
			REG_CONST_COUNT: cfg.const_count = val[15:0];
			REG_STR_COUNT:   cfg.string_count = val[15:0];
			REG_BODY_LEN:    cfg.body_length = val[15:0];
			REG_RET_REG:     cfg.return_register = val[7:0];
			REG_RET_EXIT:    cfg.return_is_exit_code = val[0];
			default: ;
		endcase
	endtask

	task automatic drain();
		in_if.valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
	endtask

	task automatic set_bounds(input int rc, input int sc, input int cc, input int strc);
		cfg_write(REG_REG_COUNT, rc);
		cfg_write(REG_SLOT_COUNT, sc);
		cfg_write(REG_CONST_COUNT, cc);
		cfg_write(REG_STR_COUNT, strc);
	endtask

	task automatic run_random(input int count);
		for (int i = 0; i < count; i++) begin
			quiet = ((i / 100) % 3) == 0;
			send_instr(gen_instr());
		end
		quiet = 0;
		drain();
	endtask

	task automatic test_directed();
		set_bounds(64, 64, 65535, 65535);
		cfg_write(REG_BODY_LEN, 65535);
		cfg_write(REG_RET_REG, 3);
		cfg_write(REG_RET_EXIT, 1);
		send_instr(mk(OP_LDC, 0, 0, 0, 0, 64'h8000_0000_0000_0000));
		send_instr(mk(OP_LDC, 1, 255, 255, 65534, 64'h7fff_ffff_ffff_ffff));
		send_instr(mk(OP_LDC, 2, 0, 0, 7, '1));
		send_instr(mk(OP_LDS, 3, 0, 0, 65534, '0));
		send_instr(mk(OP_LDC, 4, 0, 0, 5, 64'd64));
		send_instr(mk(OP_LDC, 5, 0, 0, 6, 64'd3));
		send_instr(mk(OP_ADD, 6, 1, 1, 0, '0));
		send_instr(mk(OP_SUB, 7, 0, 1, 0, '0));
		send_instr(mk(OP_MUL, 8, 1, 1, 0, '0));
		send_instr(mk(OP_DIV, 9, 0, 2, 0, '0));
		send_instr(mk(OP_REM, 10, 0, 2, 0, '0));
		send_instr(mk(OP_DIV, 11, 0, 5, 0, '0));
		send_instr(mk(OP_REM, 12, 7, 5, 0, '0));
		send_instr(mk(OP_LT, 13, 0, 1, 0, '0));
		send_instr(mk(OP_GE, 14, 2, 0, 0, '0));
		send_instr(mk(OP_LAND, 15, 0, 63, 0, '0));
		send_instr(mk(OP_LOR, 16, 63, 2, 0, '0));
		send_instr(mk(OP_SHL, 17, 1, 4, 0, '0));
		send_instr(mk(OP_SHR, 18, 0, 4, 0, '0));
		send_instr(mk(OP_SHR, 19, 0, 5, 0, '0));
		send_instr(mk(OP_NEG, 20, 0, 0, 0, '0));
		send_instr(mk(OP_LNOT, 21, 63, 0, 0, '0));
		send_instr(mk(OP_SST, 0, 1, 0, 63, '0));
		send_instr(mk(OP_SLD, 63, 0, 0, 63, '0));
		send_instr(mk(OP_BR, 0, 62, 0, 9, '0));
		send_instr(mk(OP_BR, 0, 1, 0, 300, '0));
		send_instr(mk(OP_JMP, 0, 0, 0, 65533, '0));
		drain();
	endtask

	task automatic test_tight_bounds();
		set_bounds(1, 0, 1, 1);
		run_random(200);
	endtask

	task automatic test_wide_bounds();
		set_bounds(127, 64, 65535, 65535);
		run_random(700);
	endtask

	task automatic test_mixed_bounds();
		for (int k = 0; k < 3; k++) begin
			set_bounds($urandom_range(2, 64), $urandom_range(0, 64),
				$urandom_range(0, 65535), $urandom_range(0, 65535));
			run_random(250);
		end
	endtask

	task automatic test_short_body();
		send_instr(mk(OP_JMP, 0, 0, 0, 0, '0));
		drain();
		cfg_write(REG_BODY_LEN, 24);
		set_bounds(64, 64, 65535, 65535);
		run_random(300);
	endtask

	task automatic test_halt();
		int unsigned rb;
		set_bounds($urandom_range(1, 64), 64, 65535, 65535);
		cfg_write(REG_BODY_LEN, pc + 10);
		cfg_write(REG_RET_REG, $urandom_range(0, 255));
		cfg_write(REG_RET_EXIT, $urandom_range(0, 1));
		rb = reg_bound();
		halt_case = $urandom_range(0, 7);
		case (halt_case)
			0: send_instr(mk(OP_RET, $urandom, $urandom, $urandom, $urandom, '0));
			1: send_instr(mk(OP_TRAP, 0, 0, 0, 0, '0));
			2: send_instr(mk($urandom_range(28, 31), 0, 0, 0, 0, '0));
			3: begin
				send_instr(mk(OP_SUB, 0, 0, 0, 0, '0));
				send_instr(mk(OP_DIV, 0, 0, 0, 0, '0));
			end
			4: send_instr(mk(OP_CPY, $urandom_range(rb, 255), 0, 0, 0, '0));
			5: begin
				send_instr(mk(OP_LDC, 0, 0, 0, 0, -64'sd5));
				send_instr(mk(OP_SHL, 0, 0, 0, 0, '0));
			end
			6: begin
				drain();
				cfg_write(REG_BODY_LEN, pc);
				send_instr(gen_instr());
			end
			default: send_instr(mk(OP_JMP, 0, 0, 0, $urandom_range(pc + 10, 65535), '0));
		endcase
		for (int i = 0; i < 12; i++) send_instr(gen_instr());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_if.valid = 1'b0;
		in_if.payload = '0;
		out_if.ready = 1'b0;
		for (int i = 0; i < 64; i++) begin
			regs[i] = '0;
			slots[i] = '0;
		end
		pc = '0;
		halt = ST_CONTINUE;
		cfg = '{reg_count: 64, default: '0};
		quiet = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_tight_bounds();
		test_wide_bounds();
		test_mixed_bounds();
		test_short_body();
		test_halt();
		$display("Executed %0d instructions over several bound settings, checked %0d results,",
			n_instr, n_results);
		$display("%0d mismatches; closing halt case %0d, final status %0d at pc %0d",
			n_errors, halt_case, halt, pc);
		if (n_errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (out_if.valid && out_if.ready) begin
			got = out_if.payload;
			n_results++;
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				n_errors++;
			end else begin
				want = pending_results.pop_front();
				if (got.run_status !== want.run_status) begin
					$display("%0t: run_status expected %0d got %0d", $time,
						want.run_status, got.run_status);
					n_errors++;
				end
				if (got.next_pc !== want.next_pc) begin
					$display("%0t: next_pc expected %0d got %0d", $time,
						want.next_pc, got.next_pc);
					n_errors++;
				end
				if (got.exit_value !== want.exit_value) begin
					$display("%0t: exit_value expected %h got %h", $time,
						want.exit_value, got.exit_value);
					n_errors++;
				end
			end
			stall_left = quiet ? 0 : $urandom_range(0, 11);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		out_if.ready <= (stall_left == 0);
	end

	always @(posedge clk) begin
		if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= 5000) begin
			$display("%0t: no beat for %0d cycles", $time, idle_cycles);
			$display("FAILED: results differ");
			$finish;
		end
	end
endmodule
